### rtl/crc8fr_pkg.sv
`timescale 1ns / 1ps

package crc8fr_pkg;

  localparam int unsigned ByteW          = 8;
  localparam int unsigned ReportedFields = 5;

  localparam logic [ByteW-1:0] CrcPoly      = 8'h07;
  localparam logic [ByteW-1:0] CrcInit      = 8'h00;
  localparam logic [ByteW-1:0] StartByteRst = 8'hAA;
  localparam logic [ByteW-1:0] EndByteRst   = 8'h55;

  // Configuration register indexes
  localparam logic RegStartByte = 1'b0;
  localparam logic RegEndByte   = 1'b1;

  typedef enum logic [1:0] {
    StatusOk     = 2'd0,
    StatusBadEnd = 2'd1,
    StatusBadCrc = 2'd2
  } status_e;

  typedef struct packed {
    status_e                                  status;
    logic [ReportedFields-1:0][ByteW-1:0]     level;
  } result_t;

  // CRC-8, MSB first, one byte per call
  function automatic logic [ByteW-1:0] crc8_update(logic [ByteW-1:0] crc,
                                                   logic [ByteW-1:0] data);
    logic [ByteW-1:0] c;
    c = crc ^ data;
    for (int b = 0; b < ByteW; b++) begin
      if (c[ByteW-1]) begin
        c = {c[ByteW-2:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[ByteW-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

### rtl/crc8fr_deframer.sv
`timescale 1ns / 1ps

module crc8fr_deframer #(
  parameter int unsigned PAYLOAD_BYTES = 5
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                byte_fire_i,
  input  logic [crc8fr_pkg::ByteW-1:0]        rx_byte_i,
  input  logic [crc8fr_pkg::ByteW-1:0]        start_byte_i,
  input  logic [crc8fr_pkg::ByteW-1:0]        end_byte_i,
  output logic                                at_end_o,
  output crc8fr_pkg::result_t                 result_o
);

  localparam int unsigned PosW = $clog2(PAYLOAD_BYTES + 3);
  localparam int unsigned IdxW = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
  localparam logic [PosW-1:0] PosHunt  = '0;
  localparam logic [PosW-1:0] PosCheck = PosW'(PAYLOAD_BYTES + 1);
  localparam logic [PosW-1:0] PosEnd   = PosW'(PAYLOAD_BYTES + 2);

  logic [PosW-1:0]                  pos_q, pos_d;
  logic [crc8fr_pkg::ByteW-1:0]     crc_q, crc_d;
  logic [crc8fr_pkg::ByteW-1:0]     check_q;
  logic [crc8fr_pkg::ByteW-1:0]     store_q [PAYLOAD_BYTES];
  logic [IdxW-1:0]                  wr_idx;
  logic                             in_payload;
  logic [crc8fr_pkg::ReportedFields-1:0][crc8fr_pkg::ByteW-1:0] rep;

  assign in_payload = (pos_q != PosHunt) && (pos_q < PosCheck);
  assign wr_idx     = IdxW'(pos_q - PosW'(1));
  assign at_end_o   = (pos_q == PosEnd);

  always_comb begin
    pos_d = pos_q;
    crc_d = crc_q;
    if (byte_fire_i) begin
      if (pos_q == PosHunt) begin
        if (rx_byte_i == start_byte_i) begin
          crc_d = crc8fr_pkg::CrcInit;
          pos_d = PosW'(1);
        end
      end else if (in_payload) begin
        crc_d = crc8fr_pkg::crc8_update(crc_q, rx_byte_i);
        pos_d = pos_q + PosW'(1);
      end else if (pos_q == PosCheck) begin
        pos_d = pos_q + PosW'(1);
      end else begin
        pos_d = PosHunt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= PosHunt;
      crc_q <= crc8fr_pkg::CrcInit;
    end else begin
      pos_q <= pos_d;
      crc_q <= crc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_fire_i && in_payload) begin
      store_q[wr_idx] <= rx_byte_i;
    end
    if (byte_fire_i && (pos_q == PosCheck)) begin
      check_q <= rx_byte_i;
    end
  end

  for (genvar k = 0; k < crc8fr_pkg::ReportedFields; k++) begin : g_rep
    if (k < PAYLOAD_BYTES) begin : g_have
      assign rep[k] = store_q[k];
    end else begin : g_none
      assign rep[k] = '0;
    end
  end

  always_comb begin
    result_o.level = '0;
    if (rx_byte_i != end_byte_i) begin
      result_o.status = crc8fr_pkg::StatusBadEnd;
    end else if (crc_q != check_q) begin
      result_o.status = crc8fr_pkg::StatusBadCrc;
    end else begin
      result_o.status = crc8fr_pkg::StatusOk;
      result_o.level  = rep;
    end
  end

endmodule

### rtl/crc8_frame_receiver.sv
`timescale 1ns / 1ps

// CRC-8 framed packet receiver.
// Input channel (in_valid_i/in_ready_o, rx_byte_i): one serial byte per
// transaction. Bytes are dropped until the start byte; then payload bytes,
// a check byte and an end byte follow. The end byte yields one transaction
// on the output channel (out_valid_o/out_ready_i) with status and payload.
// The result is registered and valid the cycle after the end byte is accepted.
// Throughput: one byte per cycle while in_ready_o is high; the CRC-8 update is combinational.
// Only the end byte needs room in the output register; all other bytes are
// taken even while a result waits, and the end byte is taken when the
// output register is empty or being drained in the same cycle.
// Configuration: cfg_we_i writes cfg_idx_i (0 start byte, 1 end byte) with
// cfg_wdata_i; write only while idle.
// Reset: start byte 0xAA, end byte 0x55, receiver hunting for a start byte,
// running CRC zero, output register empty.

module crc8_frame_receiver #(
  parameter int unsigned PAYLOAD_BYTES = 5
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] status_o,
  output logic [7:0] device_id_o,
  output logic [7:0] red_level_o,
  output logic [7:0] green_level_o,
  output logic [7:0] blue_level_o,
  output logic [7:0] brightness_level_o
);

  logic [7:0]           start_byte_q;
  logic [7:0]           end_byte_q;
  logic                 in_fire;
  logic                 at_end;
  crc8fr_pkg::result_t  result;
  crc8fr_pkg::result_t  res_q;
  logic                 out_valid_q, out_valid_d;

  assign in_ready_o = !at_end || !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_byte_q <= crc8fr_pkg::StartByteRst;
      end_byte_q   <= crc8fr_pkg::EndByteRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        crc8fr_pkg::RegStartByte: start_byte_q <= cfg_wdata_i;
        crc8fr_pkg::RegEndByte:   end_byte_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  crc8fr_deframer #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_deframer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_fire_i (in_fire),
    .rx_byte_i   (rx_byte_i),
    .start_byte_i(start_byte_q),
    .end_byte_i  (end_byte_q),
    .at_end_o    (at_end),
    .result_o    (result)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_fire && at_end) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && at_end) begin
      res_q <= result;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign status_o           = res_q.status;
  assign device_id_o        = res_q.level[0];
  assign red_level_o        = res_q.level[1];
  assign green_level_o      = res_q.level[2];
  assign blue_level_o       = res_q.level[3];
  assign brightness_level_o = res_q.level[4];

  a_end_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && at_end |=> out_valid_o)
    else $error("end byte accepted without a result");

  a_no_result_mid_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o && !(in_fire && at_end) |=> !out_valid_o)
    else $error("result appeared without an end byte");

  a_bad_frame_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != crc8fr_pkg::StatusOk) |->
      (device_id_o == 8'd0) && (red_level_o == 8'd0) && (green_level_o == 8'd0) &&
      (blue_level_o == 8'd0) && (brightness_level_o == 8'd0))
    else $error("bad frame carries payload");

endmodule
